// File: design/spct_pkg.sv
package spct_pkg;

   // shape kind codes
   localparam logic [1:0] KIND_PLANE  = 2'd0;
   localparam logic [1:0] KIND_CIRCLE = 2'd1;
   localparam logic [1:0] KIND_BOX    = 2'd2;

   // pair categories after operand swap
   localparam logic [2:0] CAT_NONE = 3'd0;
   localparam logic [2:0] CAT_PC   = 3'd1;   // plane, circle
   localparam logic [2:0] CAT_PB   = 3'd2;   // plane, box
   localparam logic [2:0] CAT_CC   = 3'd3;   // circle, circle
   localparam logic [2:0] CAT_CB   = 3'd4;   // circle, box
   localparam logic [2:0] CAT_BB   = 3'd5;   // box, box

   localparam logic signed [15:0] Q14_ONE = 16'sd16384;

   // per-request side data carried down the square root and divider stages
   typedef struct packed {
      logic               hit;
      logic               use_dir;
      logic signed [15:0] nfx;
      logic signed [15:0] nfy;
      logic               neg_x;
      logic               neg_y;
      logic [30:0]        hx;
      logic [30:0]        hy;
   } spct_carry_type;

endpackage

// File: design/spct_front.sv
module spct_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [1:0]            kind_a,
   input  logic [1:0]            kind_b,
   input  logic signed [31:0]    a_p0,
   input  logic signed [31:0]    a_p1,
   input  logic signed [31:0]    a_p2,
   input  logic signed [31:0]    a_p3,
   input  logic signed [31:0]    b_p0,
   input  logic signed [31:0]    b_p1,
   input  logic signed [31:0]    b_p2,
   input  logic signed [31:0]    b_p3,
   output logic                  out_valid,
   output spct_pkg::spct_carry_type out_carry,
   output logic [63:0]           out_rad
);
   import spct_pkg::*;

   // Q16.16 to Q2.14, rounded half up and saturated
   function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
      logic signed [32:0] t;
      logic signed [30:0] q;
      logic signed [15:0] r;
      t = {v[31], v} + 33'sd2;
      q = t[32:2];
      if (q > 31'sd16384) r = Q14_ONE;
      else if (q < -31'sd16384) r = -Q14_ONE;
      else r = q[15:0];
      return r;
   endfunction

   // ---------------- stage 1: decode and operand swap
   logic [2:0]         cat_in;
   logic               swap_in;
   logic signed [31:0] p_in [4];
   logic signed [31:0] q_in [4];

   logic               s1_valid_ff;
   logic [2:0]         s1_cat_ff;
   logic signed [31:0] s1_p_ff [4];
   logic signed [31:0] s1_q_ff [4];

   always_comb begin
      cat_in  = CAT_NONE;
      swap_in = 1'b0;
      case ({kind_a, kind_b})
         {KIND_PLANE, KIND_CIRCLE}: cat_in = CAT_PC;
         {KIND_CIRCLE, KIND_PLANE}: begin
            cat_in  = CAT_PC;
            swap_in = 1'b1;
         end
         {KIND_PLANE, KIND_BOX}: cat_in = CAT_PB;
         {KIND_BOX, KIND_PLANE}: begin
            cat_in  = CAT_PB;
            swap_in = 1'b1;
         end
         {KIND_CIRCLE, KIND_CIRCLE}: cat_in = CAT_CC;
         {KIND_CIRCLE, KIND_BOX}: cat_in = CAT_CB;
         {KIND_BOX, KIND_CIRCLE}: begin
            cat_in  = CAT_CB;
            swap_in = 1'b1;
         end
         {KIND_BOX, KIND_BOX}: cat_in = CAT_BB;
         default: cat_in = CAT_NONE;
      endcase
      if (swap_in) begin
         p_in = '{b_p0, b_p1, b_p2, b_p3};
         q_in = '{a_p0, a_p1, a_p2, a_p3};
      end else begin
         p_in = '{a_p0, a_p1, a_p2, a_p3};
         q_in = '{b_p0, b_p1, b_p2, b_p3};
      end
   end

   // ---------------- stage 2: products, differences, clamps
   logic signed [63:0] s2_m_in [4];
   logic signed [32:0] s2_dx_in, s2_dy_in, s2_rr_in;
   logic               s2_ov_in;

   logic               s2_valid_ff;
   logic [2:0]         s2_cat_ff;
   logic signed [63:0] s2_m_ff [4];
   logic signed [31:0] s2_d_ff;
   logic signed [32:0] s2_dx_ff, s2_dy_ff, s2_rr_ff;
   logic               s2_ov_ff;
   logic signed [32:0] s2_bspx_ff, s2_bsqx_ff, s2_bspy_ff, s2_bsqy_ff;
   logic signed [15:0] s2_pnx_ff, s2_pny_ff;

   always_comb begin
      logic signed [31:0] tx1, tx2, ty1, ty2;
      s2_m_in[0] = s1_p_ff[0] * s1_q_ff[0];
      s2_m_in[1] = s1_p_ff[1] * s1_q_ff[1];
      s2_m_in[2] = s1_p_ff[0] * s1_q_ff[2];
      s2_m_in[3] = s1_p_ff[1] * s1_q_ff[3];
      // clamp the circle centre into the box, max bound wins
      tx1 = (s1_p_ff[0] < s1_q_ff[0]) ? s1_q_ff[0] : s1_p_ff[0];
      tx2 = (tx1 > s1_q_ff[2]) ? s1_q_ff[2] : tx1;
      ty1 = (s1_p_ff[1] < s1_q_ff[1]) ? s1_q_ff[1] : s1_p_ff[1];
      ty2 = (ty1 > s1_q_ff[3]) ? s1_q_ff[3] : ty1;
      if (s1_cat_ff == CAT_CB) begin
         s2_dx_in = {tx2[31], tx2} - {s1_p_ff[0][31], s1_p_ff[0]};
         s2_dy_in = {ty2[31], ty2} - {s1_p_ff[1][31], s1_p_ff[1]};
      end else begin
         s2_dx_in = {s1_q_ff[0][31], s1_q_ff[0]} - {s1_p_ff[0][31], s1_p_ff[0]};
         s2_dy_in = {s1_q_ff[1][31], s1_q_ff[1]} - {s1_p_ff[1][31], s1_p_ff[1]};
      end
      // radius used by the distance tests
      case (s1_cat_ff)
         CAT_CC:  s2_rr_in = {s1_p_ff[2][31], s1_p_ff[2]} + {s1_q_ff[2][31], s1_q_ff[2]};
         CAT_CB:  s2_rr_in = {s1_p_ff[2][31], s1_p_ff[2]};
         default: s2_rr_in = {s1_q_ff[2][31], s1_q_ff[2]};
      endcase
      s2_ov_in = (s1_p_ff[0] < s1_q_ff[2]) && (s1_p_ff[2] > s1_q_ff[0]) &&
                 (s1_p_ff[1] < s1_q_ff[3]) && (s1_p_ff[3] > s1_q_ff[1]);
   end

   // ---------------- stage 3: plane distances, magnitudes
   logic signed [49:0] s3_s_in [4];
   logic [32:0]        dxm, dym;
   logic [49:0]        ef [4];
   logic [49:0]        ed;

   logic               s3_valid_ff;
   logic [2:0]         s3_cat_ff;
   logic signed [49:0] s3_s_ff [4];
   logic [31:0]        s3_ax_ff, s3_ay_ff;
   logic               s3_negx_ff, s3_negy_ff, s3_rok_ff;
   logic [31:0]        s3_rmag_ff;
   logic signed [33:0] s3_bdx_ff, s3_bdy_ff;
   logic               s3_ov_ff;
   logic signed [15:0] s3_pnx_ff, s3_pny_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ef[i] = {{2{s2_m_ff[i][63]}}, s2_m_ff[i][63:16]};
      end
      ed = {{18{s2_d_ff[31]}}, s2_d_ff};
      // corners: min/min, min/max, max/max, max/min
      s3_s_in[0] = ef[0] + ef[1] - ed;
      s3_s_in[1] = ef[0] + ef[3] - ed;
      s3_s_in[2] = ef[2] + ef[3] - ed;
      s3_s_in[3] = ef[2] + ef[1] - ed;
      dxm = s2_dx_ff[32] ? (33'd0 - s2_dx_ff) : s2_dx_ff;
      dym = s2_dy_ff[32] ? (33'd0 - s2_dy_ff) : s2_dy_ff;
   end

   // ---------------- stage 4: squares, side tests
   logic [49:0] s4_sa_in;
   logic        below, above;
   logic        sh;
   logic [30:0] hx, hy;
   logic [33:0] bxm, bym;

   logic               s4_valid_ff;
   logic [2:0]         s4_cat_ff;
   logic               s4_neg_ff;
   logic [49:0]        s4_sa_ff;
   logic               s4_pbhit_ff;
   logic [63:0]        s4_sqx_ff, s4_sqy_ff, s4_sqr_ff;
   logic [61:0]        s4_hx2_ff, s4_hy2_ff;
   logic [30:0]        s4_hx_ff, s4_hy_ff;
   logic               s4_negx_ff, s4_negy_ff, s4_rok_ff;
   logic [31:0]        s4_rmag_ff;
   logic [32:0]        s4_abx_ff, s4_aby_ff;
   logic               s4_bnegx_ff, s4_bnegy_ff, s4_bdynz_ff;
   logic               s4_ov_ff;
   logic signed [15:0] s4_pnx_ff, s4_pny_ff;

   always_comb begin
      s4_sa_in = s3_s_ff[0][49] ? (50'd0 - s3_s_ff[0]) : s3_s_ff[0];
      below = 1'b0;
      above = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (s3_s_ff[i][49] || (s3_s_ff[i] == 50'sd0)) below = 1'b1;
         else above = 1'b1;
      end
      // halve both when either needs the top bit
      sh  = s3_ax_ff[31] | s3_ay_ff[31];
      hx  = sh ? s3_ax_ff[31:1] : s3_ax_ff[30:0];
      hy  = sh ? s3_ay_ff[31:1] : s3_ay_ff[30:0];
      bxm = s3_bdx_ff[33] ? (34'd0 - s3_bdx_ff) : s3_bdx_ff;
      bym = s3_bdy_ff[33] ? (34'd0 - s3_bdy_ff) : s3_bdy_ff;
   end

   // ---------------- stage 5: compares and normal selection
   logic [64:0]    sumw;
   logic           reach_ok, pc_hit;
   spct_carry_type s5_carry_in;
   logic [63:0]    s5_rad_in;

   logic           s5_valid_ff;
   spct_carry_type s5_carry_ff;
   logic [63:0]    s5_rad_ff;

   always_comb begin
      sumw      = {1'b0, s4_sqx_ff} + {1'b0, s4_sqy_ff};
      reach_ok  = s4_rok_ff && (sumw <= {1'b0, s4_sqr_ff});
      pc_hit    = s4_rok_ff && ({18'd0, s4_rmag_ff} > s4_sa_ff);
      s5_rad_in = {2'b00, s4_hx2_ff} + {2'b00, s4_hy2_ff};
      s5_carry_in         = '0;
      s5_carry_in.neg_x   = s4_negx_ff;
      s5_carry_in.neg_y   = s4_negy_ff;
      s5_carry_in.hx      = s4_hx_ff;
      s5_carry_in.hy      = s4_hy_ff;
      case (s4_cat_ff)
         CAT_PC: begin
            s5_carry_in.hit = pc_hit;
            s5_carry_in.nfx = s4_neg_ff ? -s4_pnx_ff : s4_pnx_ff;
            s5_carry_in.nfy = s4_neg_ff ? -s4_pny_ff : s4_pny_ff;
         end
         CAT_PB: begin
            s5_carry_in.hit = s4_pbhit_ff;
            s5_carry_in.nfx = s4_pnx_ff;
            s5_carry_in.nfy = s4_pny_ff;
         end
         CAT_CC, CAT_CB: begin
            s5_carry_in.hit     = reach_ok;
            s5_carry_in.use_dir = 1'b1;
         end
         CAT_BB: begin
            s5_carry_in.hit = s4_ov_ff;
            if (s4_abx_ff > s4_aby_ff) begin
               s5_carry_in.nfx = s4_bnegx_ff ? -Q14_ONE : Q14_ONE;
            end else if (s4_bdynz_ff) begin
               s5_carry_in.nfy = s4_bnegy_ff ? -Q14_ONE : Q14_ONE;
            end
         end
         default: s5_carry_in.hit = 1'b0;
      endcase
   end

   // ---------------- valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         s1_cat_ff <= cat_in;
         s1_p_ff   <= p_in;
         s1_q_ff   <= q_in;

         s2_cat_ff  <= s1_cat_ff;
         s2_m_ff    <= s2_m_in;
         s2_d_ff    <= s1_p_ff[2];
         s2_dx_ff   <= s2_dx_in;
         s2_dy_ff   <= s2_dy_in;
         s2_rr_ff   <= s2_rr_in;
         s2_ov_ff   <= s2_ov_in;
         s2_bspx_ff <= {s1_p_ff[0][31], s1_p_ff[0]} + {s1_p_ff[2][31], s1_p_ff[2]};
         s2_bsqx_ff <= {s1_q_ff[0][31], s1_q_ff[0]} + {s1_q_ff[2][31], s1_q_ff[2]};
         s2_bspy_ff <= {s1_p_ff[1][31], s1_p_ff[1]} + {s1_p_ff[3][31], s1_p_ff[3]};
         s2_bsqy_ff <= {s1_q_ff[1][31], s1_q_ff[1]} + {s1_q_ff[3][31], s1_q_ff[3]};
         s2_pnx_ff  <= to_q14(s1_p_ff[0]);
         s2_pny_ff  <= to_q14(s1_p_ff[1]);

         s3_cat_ff  <= s2_cat_ff;
         s3_s_ff    <= s3_s_in;
         s3_ax_ff   <= dxm[31:0];
         s3_ay_ff   <= dym[31:0];
         s3_negx_ff <= s2_dx_ff[32];
         s3_negy_ff <= s2_dy_ff[32];
         s3_rok_ff  <= ~s2_rr_ff[32];
         s3_rmag_ff <= s2_rr_ff[31:0];
         s3_bdx_ff  <= {s2_bsqx_ff[32], s2_bsqx_ff} - {s2_bspx_ff[32], s2_bspx_ff};
         s3_bdy_ff  <= {s2_bsqy_ff[32], s2_bsqy_ff} - {s2_bspy_ff[32], s2_bspy_ff};
         s3_ov_ff   <= s2_ov_ff;
         s3_pnx_ff  <= s2_pnx_ff;
         s3_pny_ff  <= s2_pny_ff;

         s4_cat_ff   <= s3_cat_ff;
         s4_neg_ff   <= s3_s_ff[0][49];
         s4_sa_ff    <= s4_sa_in;
         s4_pbhit_ff <= below & above;
         s4_sqx_ff   <= s3_ax_ff * s3_ax_ff;
         s4_sqy_ff   <= s3_ay_ff * s3_ay_ff;
         s4_sqr_ff   <= s3_rmag_ff * s3_rmag_ff;
         s4_hx2_ff   <= hx * hx;
         s4_hy2_ff   <= hy * hy;
         s4_hx_ff    <= hx;
         s4_hy_ff    <= hy;
         s4_negx_ff  <= s3_negx_ff;
         s4_negy_ff  <= s3_negy_ff;
         s4_rok_ff   <= s3_rok_ff;
         s4_rmag_ff  <= s3_rmag_ff;
         s4_abx_ff   <= bxm[32:0];
         s4_aby_ff   <= bym[32:0];
         s4_bnegx_ff <= s3_bdx_ff[33];
         s4_bnegy_ff <= s3_bdy_ff[33];
         s4_bdynz_ff <= (s3_bdy_ff != 34'sd0);
         s4_ov_ff    <= s3_ov_ff;
         s4_pnx_ff   <= s3_pnx_ff;
         s4_pny_ff   <= s3_pny_ff;

         s5_carry_ff <= s5_carry_in;
         s5_rad_ff   <= s5_rad_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_carry = s5_carry_ff;
   assign out_rad   = s5_rad_ff;

endmodule

// File: design/spct_isqrt.sv
module spct_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  spct_pkg::spct_carry_type in_carry,
   input  logic [63:0]           in_rad,
   output logic                  out_valid,
   output spct_pkg::spct_carry_type out_carry,
   output logic [31:0]           out_root
);
   import spct_pkg::*;

   // one root bit per stage
   localparam int STAGES = 32;

   logic [STAGES-1:0] valid_ff;
   spct_carry_type    carry_ff [STAGES];
   spct_carry_type    carry_in [STAGES];
   logic [32:0]       rem_ff   [STAGES];
   logic [32:0]       rem_in   [STAGES];
   logic [31:0]       root_ff  [STAGES];
   logic [31:0]       root_in  [STAGES];
   logic [63:0]       rad_ff   [STAGES];
   logic [63:0]       rad_in   [STAGES];

   // digit recurrence, two radicand bits per stage
   always_comb begin
      logic [32:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] rad_p;
      logic [34:0] remsh, trial;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            rem_p       = '0;
            root_p      = '0;
            rad_p       = in_rad;
            carry_in[k] = in_carry;
         end else begin
            rem_p       = rem_ff[k-1];
            root_p      = root_ff[k-1];
            rad_p       = rad_ff[k-1];
            carry_in[k] = carry_ff[k-1];
         end
         remsh = {rem_p, rad_p[63:62]};
         trial = {1'b0, root_p, 2'b01};
         if (remsh >= trial) begin
            rem_in[k]  = 33'(remsh - trial);
            root_in[k] = {root_p[30:0], 1'b1};
         end else begin
            rem_in[k]  = remsh[32:0];
            root_in[k] = {root_p[30:0], 1'b0};
         end
         rad_in[k] = {rad_p[61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         carry_ff <= carry_in;
         rem_ff   <= rem_in;
         root_ff  <= root_in;
         rad_ff   <= rad_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_carry = carry_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];

endmodule

// File: design/spct_div.sv
module spct_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  spct_pkg::spct_carry_type in_carry,
   input  logic [31:0]           in_len,
   output logic                  out_valid,
   output spct_pkg::spct_carry_type out_carry,
   output logic [14:0]           out_qx,
   output logic [14:0]           out_qy,
   output logic                  out_len_zero
);
   import spct_pkg::*;

   // one quotient bit per stage; quotient never exceeds Q14 one
   localparam int STAGES = 15;

   // ---------------- prep: rounded numerators
   logic           prep_valid_ff;
   spct_carry_type prep_carry_ff;
   logic [31:0]    prep_len_ff;
   logic [45:0]    prep_num_ff [2];

   // ---------------- iteration stages, lane 0 is x, lane 1 is y
   logic [STAGES-1:0] valid_ff;
   spct_carry_type    carry_ff [STAGES];
   spct_carry_type    carry_in [STAGES];
   logic [31:0]       len_ff   [STAGES];
   logic [31:0]       len_in   [STAGES];
   logic [31:0]       rem_ff   [STAGES][2];
   logic [31:0]       rem_in   [STAGES][2];
   logic [45:0]       num_ff   [STAGES][2];
   logic [45:0]       num_in   [STAGES][2];
   logic [14:0]       q_ff     [STAGES][2];
   logic [14:0]       q_in     [STAGES][2];

   always_comb begin
      logic [31:0] rem_p;
      logic [45:0] num_p;
      logic [14:0] q_p;
      logic [31:0] len_p;
      logic [32:0] t;
      for (int j = 0; j < STAGES; j++) begin
         if (j == 0) begin
            carry_in[j] = prep_carry_ff;
            len_p       = prep_len_ff;
         end else begin
            carry_in[j] = carry_ff[j-1];
            len_p       = len_ff[j-1];
         end
         len_in[j] = len_p;
         for (int l = 0; l < 2; l++) begin
            if (j == 0) begin
               num_p = prep_num_ff[l];
               rem_p = {1'b0, prep_num_ff[l][45:15]};
               q_p   = '0;
            end else begin
               num_p = num_ff[j-1][l];
               rem_p = rem_ff[j-1][l];
               q_p   = q_ff[j-1][l];
            end
            t = {rem_p, num_p[14-j]};
            if (t >= {1'b0, len_p}) begin
               rem_in[j][l] = 32'(t - {1'b0, len_p});
               q_in[j][l]   = {q_p[13:0], 1'b1};
            end else begin
               rem_in[j][l] = t[31:0];
               q_in[j][l]   = {q_p[13:0], 1'b0};
            end
            num_in[j][l] = num_p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
         valid_ff      <= '0;
      end else if (en) begin
         prep_valid_ff <= in_valid;
         valid_ff      <= {valid_ff[STAGES-2:0], prep_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_carry_ff  <= in_carry;
         prep_len_ff    <= in_len;
         prep_num_ff[0] <= {1'b0, in_carry.hx, 14'd0} + {15'd0, in_len[31:1]};
         prep_num_ff[1] <= {1'b0, in_carry.hy, 14'd0} + {15'd0, in_len[31:1]};
         carry_ff       <= carry_in;
         len_ff         <= len_in;
         rem_ff         <= rem_in;
         num_ff         <= num_in;
         q_ff           <= q_in;
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_carry    = carry_ff[STAGES-1];
   assign out_qx       = q_ff[STAGES-1][0];
   assign out_qy       = q_ff[STAGES-1][1];
   assign out_len_zero = (len_ff[STAGES-1] == 32'd0);

endmodule

// File: design/shape_pair_collision_test_unit.sv
// From request acceptance to rsp_valid a request passes 5 setup stages, a
//   32-stage square root, a 16-stage divider and the output register.
// Throughput: one request per cycle when not stalled; every stage holds its own request.
// Output register plus one skid entry; the pipeline stalls as a whole only when both hold.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
module shape_pair_collision_test_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind_a,
   input  logic [1:0]         req_kind_b,
   input  logic signed [31:0] req_a_p0,
   input  logic signed [31:0] req_a_p1,
   input  logic signed [31:0] req_a_p2,
   input  logic signed [31:0] req_a_p3,
   input  logic signed [31:0] req_b_p0,
   input  logic signed [31:0] req_b_p1,
   input  logic signed [31:0] req_b_p2,
   input  logic signed [31:0] req_b_p3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y
);
   import spct_pkg::*;

   logic           en;
   logic           f_valid, r_valid, d_valid;
   spct_carry_type f_carry, r_carry, d_carry;
   logic [63:0]    f_rad;
   logic [31:0]    r_root;
   logic [14:0]    d_qx, d_qy;
   logic           d_len_zero;

   logic               res_hit;
   logic signed [15:0] res_nx, res_ny;
   logic               push, take;

   logic               out_valid_ff, skid_valid_ff;
   logic               out_hit_ff, skid_hit_ff;
   logic signed [15:0] out_nx_ff, out_ny_ff, skid_nx_ff, skid_ny_ff;

   // whole pipeline moves unless the skid entry is occupied
   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   spct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .kind_a    (req_kind_a),
      .kind_b    (req_kind_b),
      .a_p0      (req_a_p0),
      .a_p1      (req_a_p1),
      .a_p2      (req_a_p2),
      .a_p3      (req_a_p3),
      .b_p0      (req_b_p0),
      .b_p1      (req_b_p1),
      .b_p2      (req_b_p2),
      .b_p3      (req_b_p3),
      .out_valid (f_valid),
      .out_carry (f_carry),
      .out_rad   (f_rad)
   );

   spct_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_carry  (f_carry),
      .in_rad    (f_rad),
      .out_valid (r_valid),
      .out_carry (r_carry),
      .out_root  (r_root)
   );

   spct_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (r_valid),
      .in_carry     (r_carry),
      .in_len       (r_root),
      .out_valid    (d_valid),
      .out_carry    (d_carry),
      .out_qx       (d_qx),
      .out_qy       (d_qy),
      .out_len_zero (d_len_zero)
   );

   // final normal: unit direction with sign, fixed normal, or zero on a miss or zero length
   always_comb begin
      res_hit = d_carry.hit;
      res_nx  = '0;
      res_ny  = '0;
      if (d_carry.hit) begin
         if (d_carry.use_dir) begin
            if (!d_len_zero) begin
               res_nx = d_carry.neg_x ? -$signed({1'b0, d_qx}) : $signed({1'b0, d_qx});
               res_ny = d_carry.neg_y ? -$signed({1'b0, d_qy}) : $signed({1'b0, d_qy});
            end
         end else begin
            res_nx = d_carry.nfx;
            res_ny = d_carry.nfy;
         end
      end
   end

   assign push = en & d_valid;
   assign take = ~out_valid_ff | rsp_ready;

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (skid_valid_ff) begin
            out_hit_ff <= skid_hit_ff;
            out_nx_ff  <= skid_nx_ff;
            out_ny_ff  <= skid_ny_ff;
         end else begin
            out_hit_ff <= res_hit;
            out_nx_ff  <= res_nx;
            out_ny_ff  <= res_ny;
         end
      end else if (push) begin
         skid_hit_ff <= res_hit;
         skid_nx_ff  <= res_nx;
         skid_ny_ff  <= res_ny;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_hit      = out_hit_ff;
   assign rsp_normal_x = out_nx_ff;
   assign rsp_normal_y = out_ny_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import spct_pkg::*;

   // kind code that names no shape
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int ONE_Q16 = 65536;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_PER_PHASE = 160;

   typedef struct {
      logic [1:0]         ka;
      logic [1:0]         kb;
      logic signed [31:0] a [4];
      logic signed [31:0] b [4];
   } pair_type;

   typedef struct packed {
      bit        hit;
      bit [15:0] nx;
      bit [15:0] ny;
   } contact_type;

   typedef struct {
      pair_type    p;
      bit          known;
      contact_type want;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind_a = '0;
   logic [1:0]         req_kind_b = '0;
   logic signed [31:0] req_a_p0 = '0, req_a_p1 = '0, req_a_p2 = '0, req_a_p3 = '0;
   logic signed [31:0] req_b_p0 = '0, req_b_p1 = '0, req_b_p2 = '0, req_b_p3 = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;

   contact_type contacts_due [$];
   row_type     directed_rows [$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_arm = 1'b0;

   shape_pair_collision_test_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind_a   (req_kind_a),
      .req_kind_b   (req_kind_b),
      .req_a_p0     (req_a_p0),
      .req_a_p1     (req_a_p1),
      .req_a_p2     (req_a_p2),
      .req_a_p3     (req_a_p3),
      .req_b_p0     (req_b_p0),
      .req_b_p1     (req_b_p1),
      .req_b_p2     (req_b_p2),
      .req_b_p3     (req_b_p3),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hit      (rsp_hit),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- contact predictor ----------------

   function automatic bit [63:0] magnitude(longint v);
      return v < 0 ? bit'(0) - 64'(v) : 64'(v);
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // signed distance of a point from the plane, Q16.16
   function automatic longint plane_offset(longint nx, longint ny, longint d,
                                           longint px, longint py);
      return ((nx * px) >>> 16) + ((ny * py) >>> 16) - d;
   endfunction

   // Q16.16 to Q2.14, round half up, saturated
   function automatic longint to_q14(longint v);
      longint q;
      q = (v + 2) >>> 2;
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q;
   endfunction

   function automatic bit in_reach(longint dx, longint dy, longint r);
      bit [63:0] ax, ay, sq, sum, r2;
      if (r < 0) return 0;
      ax = magnitude(dx);
      ay = magnitude(dy);
      sq = ax * ax;
      sum = sq + ay * ay;
      r2 = 64'(r) * 64'(r);
      if (sum < sq) return 0;
      return sum <= r2;
   endfunction

   function automatic void unit_normal(longint dx, longint dy,
                                       output longint ox, output longint oy);
      bit [63:0] ax, ay, len, qx, qy;
      ax = magnitude(dx);
      ay = magnitude(dy);
      while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
         ax >>= 1;
         ay >>= 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      if (len == 0) begin
         ox = 0;
         oy = 0;
         return;
      end
      qx = (ax * 16384 + len / 2) / len;
      qy = (ay * 16384 + len / 2) / len;
      ox = dx < 0 ? -longint'(qx) : longint'(qx);
      oy = dy < 0 ? -longint'(qy) : longint'(qy);
   endfunction

   function automatic bit plane_vs_circle(longint pl [4], longint ci [4],
                                          output longint nx, output longint ny);
      longint s, x, y;
      s = plane_offset(pl[0], pl[1], pl[2], ci[0], ci[1]);
      x = to_q14(pl[0]);
      y = to_q14(pl[1]);
      if (s < 0) begin
         x = -x;
         y = -y;
         s = -s;
      end
      nx = x;
      ny = y;
      return ci[2] > s;
   endfunction

   function automatic bit plane_vs_box(longint pl [4], longint bx [4],
                                       output longint nx, output longint ny);
      bit lo_side, hi_side;
      longint px, py;
      lo_side = 0;
      hi_side = 0;
      for (int i = 0; i < 4; i++) begin
         px = (i >= 2) ? bx[2] : bx[0];
         py = (i == 1 || i == 2) ? bx[3] : bx[1];
         if (plane_offset(pl[0], pl[1], pl[2], px, py) <= 0) lo_side = 1;
         else hi_side = 1;
      end
      nx = to_q14(pl[0]);
      ny = to_q14(pl[1]);
      return lo_side && hi_side;
   endfunction

   function automatic bit circle_vs_box(longint ci [4], longint bx [4],
                                        output longint nx, output longint ny);
      longint cx, cy;
      cx = ci[0];
      if (cx < bx[0]) cx = bx[0];
      if (cx > bx[2]) cx = bx[2];
      cy = ci[1];
      if (cy < bx[1]) cy = bx[1];
      if (cy > bx[3]) cy = bx[3];
      if (!in_reach(cx - ci[0], cy - ci[1], ci[2])) return 0;
      unit_normal(cx - ci[0], cy - ci[1], nx, ny);
      return 1;
   endfunction

   function automatic bit box_vs_box(longint a [4], longint b [4],
                                     output longint nx, output longint ny);
      longint dx, dy;
      nx = 0;
      ny = 0;
      if (!(a[0] < b[2] && a[2] > b[0] && a[1] < b[3] && a[3] > b[1])) return 0;
      dx = (b[0] + b[2]) - (a[0] + a[2]);
      dy = (b[1] + b[3]) - (a[1] + a[3]);
      if (magnitude(dx) > magnitude(dy)) nx = dx > 0 ? 16384 : -16384;
      else if (dy != 0) ny = dy > 0 ? 16384 : -16384;
      return 1;
   endfunction

   function automatic contact_type collide_pair(pair_type p);
      longint a [4], b [4], nx, ny;
      bit hit;
      contact_type c;
      for (int i = 0; i < 4; i++) begin
         a[i] = longint'(p.a[i]);
         b[i] = longint'(p.b[i]);
      end
      nx = 0;
      ny = 0;
      hit = 0;
      case ({p.ka, p.kb})
         {KIND_PLANE, KIND_CIRCLE}:  hit = plane_vs_circle(a, b, nx, ny);
         {KIND_CIRCLE, KIND_PLANE}:  hit = plane_vs_circle(b, a, nx, ny);
         {KIND_PLANE, KIND_BOX}:     hit = plane_vs_box(a, b, nx, ny);
         {KIND_BOX, KIND_PLANE}:     hit = plane_vs_box(b, a, nx, ny);
         {KIND_CIRCLE, KIND_CIRCLE}: begin
            hit = in_reach(b[0] - a[0], b[1] - a[1], a[2] + b[2]);
            if (hit) unit_normal(b[0] - a[0], b[1] - a[1], nx, ny);
         end
         {KIND_CIRCLE, KIND_BOX}:    hit = circle_vs_box(a, b, nx, ny);
         {KIND_BOX, KIND_CIRCLE}:    hit = circle_vs_box(b, a, nx, ny);
         {KIND_BOX, KIND_BOX}:       hit = box_vs_box(a, b, nx, ny);
         default: hit = 0;
      endcase
      c.hit = hit;
      c.nx = hit ? 16'(nx) : 16'd0;
      c.ny = hit ? 16'(ny) : 16'd0;
      return c;
   endfunction

   // ---------------- stimulus ----------------

   task automatic add_row(logic [1:0] ka, logic [1:0] kb,
                          int a0, int a1, int a2, int a3,
                          int b0, int b1, int b2, int b3,
                          bit known, bit hit, int nx, int ny);
      row_type r;
      r.p.ka = ka;
      r.p.kb = kb;
      r.p.a = '{a0, a1, a2, a3};
      r.p.b = '{b0, b1, b2, b3};
      r.known = known;
      r.want.hit = hit;
      r.want.nx = 16'(nx);
      r.want.ny = 16'(ny);
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // random shape: mostly small, overlapping geometry, some raw bit patterns
   function automatic void make_shape(logic [1:0] k, output logic signed [31:0] s [4]);
      int lo, span;
      if ($urandom_range(7) == 0) begin
         for (int i = 0; i < 4; i++) s[i] = $urandom;
         return;
      end
      case (k)
         KIND_PLANE: begin
            s[0] = $urandom_range(2 * ONE_Q16) - ONE_Q16;
            s[1] = $urandom_range(2 * ONE_Q16) - ONE_Q16;
            s[2] = $urandom_range(4 * ONE_Q16) - 2 * ONE_Q16;
            s[3] = $urandom;
         end
         KIND_CIRCLE: begin
            s[0] = $urandom_range(8 * ONE_Q16) - 4 * ONE_Q16;
            s[1] = $urandom_range(8 * ONE_Q16) - 4 * ONE_Q16;
            s[2] = $urandom_range(3 * ONE_Q16) - ($urandom_range(9) == 0 ? ONE_Q16 : 0);
            s[3] = $urandom;
         end
         default: begin
            for (int i = 0; i < 2; i++) begin
               lo = $urandom_range(8 * ONE_Q16) - 4 * ONE_Q16;
               span = $urandom_range(4 * ONE_Q16);
               s[i] = lo;
               s[i + 2] = ($urandom_range(9) == 0) ? lo - span : lo + span;
            end
         end
      endcase
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      p.ka = ($urandom_range(15) == 0) ? KIND_NONE : 2'($urandom_range(2));
      p.kb = ($urandom_range(15) == 0) ? KIND_NONE : 2'($urandom_range(2));
      make_shape(p.ka, p.a);
      make_shape(p.kb, p.b);
      return p;
   endfunction

   // offer one request, wait for it to be taken, then maybe go idle
   task automatic send_pair(pair_type p);
      req_valid  <= 1'b1;
      req_kind_a <= p.ka;
      req_kind_b <= p.kb;
      req_a_p0 <= p.a[0];
      req_a_p1 <= p.a[1];
      req_a_p2 <= p.a[2];
      req_a_p3 <= p.a[3];
      req_b_p0 <= p.b[0];
      req_b_p1 <= p.b[1];
      req_b_p2 <= p.b[2];
      req_b_p3 <= p.b[3];
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   initial begin
      pair_type p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: kinds, extremes and the degenerate cases
      add_row(KIND_PLANE, KIND_PLANE, ONE_Q16, 0, 0, 0, 0, ONE_Q16, 0, 0, 1, 0, 0, 0);
      add_row(KIND_NONE, KIND_CIRCLE, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16, 0, 1, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_NONE, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16, 0, 1, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_CIRCLE, 5, 7, ONE_Q16, 0, 5, 7, ONE_Q16, 0, 1, 1, 0, 0);
      add_row(KIND_CIRCLE, KIND_CIRCLE, 0, 0, ONE_Q16, 0, 9 * ONE_Q16, 0, ONE_Q16, 0,
              1, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_CIRCLE, 0, 0, 2 * ONE_Q16, 0, 3 * ONE_Q16, 4 * ONE_Q16,
              3 * ONE_Q16, 0, 0, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_CIRCLE, 0, 0, -ONE_Q16, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(KIND_PLANE, KIND_CIRCLE, ONE_Q16, 0, 0, 0, -ONE_Q16 / 2, 0, ONE_Q16, 0,
              0, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_PLANE, 0, ONE_Q16 / 2, ONE_Q16, 0, 0, ONE_Q16, 0, 0,
              0, 0, 0, 0);
      add_row(KIND_PLANE, KIND_CIRCLE, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 0, 0);
      add_row(KIND_PLANE, KIND_BOX, ONE_Q16, ONE_Q16, 0, 0, -ONE_Q16, -ONE_Q16,
              ONE_Q16, ONE_Q16, 0, 0, 0, 0);
      add_row(KIND_BOX, KIND_PLANE, ONE_Q16, ONE_Q16, 2 * ONE_Q16, 2 * ONE_Q16,
              ONE_Q16, 0, 0, 0, 0, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_BOX, 0, 0, 1, 0, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16,
              1, 1, 0, 0);
      add_row(KIND_BOX, KIND_CIRCLE, 2 * ONE_Q16, 0, ONE_Q16, ONE_Q16, 0, 0,
              2 * ONE_Q16, 0, 0, 0, 0, 0);
      add_row(KIND_BOX, KIND_BOX, 0, 0, 2 * ONE_Q16, 2 * ONE_Q16, ONE_Q16, 0,
              3 * ONE_Q16, 2 * ONE_Q16, 1, 1, 16384, 0);
      add_row(KIND_BOX, KIND_BOX, 0, 0, ONE_Q16, ONE_Q16, 0, 0, ONE_Q16, ONE_Q16,
              1, 1, 0, 0);
      add_row(KIND_BOX, KIND_BOX, 0, 0, ONE_Q16, ONE_Q16, ONE_Q16, 0, 2 * ONE_Q16,
              ONE_Q16, 1, 0, 0, 0);
      add_row(KIND_BOX, KIND_BOX, 0, 0, ONE_Q16, 3 * ONE_Q16, 0, ONE_Q16 / 2, ONE_Q16,
              4 * ONE_Q16, 0, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_CIRCLE, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              1, 0, 0, 0);
      add_row(KIND_CIRCLE, KIND_CIRCLE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              1, 1, 0, 0);
      add_row(KIND_CIRCLE, KIND_CIRCLE, 32'h80000000, 32'h80000000, 32'h7fffffff, 0,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0);
      add_row(KIND_PLANE, KIND_CIRCLE, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 0);
      add_row(KIND_BOX, KIND_PLANE, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, 0);

      // typed results must agree with the predictor that checks the block
      foreach (directed_rows[i]) begin
         if (directed_rows[i].known &&
             directed_rows[i].want != collide_pair(directed_rows[i].p)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: typed result disagrees with predictor", i);
         end
         send_pair(directed_rows[i].p);
      end

      // random phases: long receiver hold, sender idle, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 32) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 58 : 32) : 0;
         if (ph == 0) hold_arm <= 1'b1;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2 && ph != 0) begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            p = random_pair();
            send_pair(p);
         end
      end
      req_valid <= 1'b0;

      while (contacts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && contacts_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // record the expected contact for every request the block takes
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         pair_type p;
         p.ka = req_kind_a;
         p.kb = req_kind_b;
         p.a = '{req_a_p0, req_a_p1, req_a_p2, req_a_p3};
         p.b = '{req_b_p0, req_b_p1, req_b_p2, req_b_p3};
         contacts_due.insert(contacts_due.size(), collide_pair(p));
      end
   end

   // result side: check, then choose next ready with stalls and the long hold
   int  hold_left = 0;
   bit  hold_done = 0;
   always @(posedge clock) begin
      contact_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (contacts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected contact: hit=%0b nx=%0d ny=%0d",
                        rsp_hit, rsp_normal_x, rsp_normal_y);
         end else begin
            want = contacts_due.pop_front();
            if (rsp_hit !== want.hit || rsp_normal_x !== want.nx
                || rsp_normal_y !== want.ny) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hit=%0b nx=%0d ny=%0d got hit=%0b nx=%0d ny=%0d",
                           want.hit, $signed(want.nx), $signed(want.ny),
                           rsp_hit, rsp_normal_x, rsp_normal_y);
            end
         end
      end
      if (hold_arm && !hold_done) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no handshake on either side
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
